// ----- rtl/core/u8sd_pkg.sv -----
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared constants and types for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned CNT_W  = 3;

  // Lead byte ranges
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MIN   = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_MAX   = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_MAX   = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_MIN   = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_MAX   = 8'hF4;

  // Special lead bytes that narrow the second byte's range
  localparam logic [BYTE_W-1:0] LEAD_E0     = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_ED     = 8'hED;
  localparam logic [BYTE_W-1:0] LEAD_F0     = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_F4     = 8'hF4;
  localparam logic [BYTE_W-1:0] BOUND_A0    = 8'hA0;
  localparam logic [BYTE_W-1:0] BOUND_90    = 8'h90;

  // Continuation byte form 10xxxxxx
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG    = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;

  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] byte_count;
    logic            invalid;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/u8sd_step.sv -----
// ----------------------------------------------------------------------------
// u8sd_step
// Sequence state and single-byte decode: consumes one byte per take and
// gives the result, if any, that the byte completes.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_step (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          take,
  input  wire logic [u8sd_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic                          end_of_string,
  output u8sd_pkg::result_t                  res
);

  logic [1:0]                     pending_r, pending_nxt;
  logic [u8sd_pkg::CP_W-1:0]      accum_r,   accum_nxt;
  logic [u8sd_pkg::BYTE_W-1:0]    lead_r,    lead_nxt;
  logic [u8sd_pkg::CNT_W-1:0]     seen_r,    seen_nxt;
  logic                           discard_r, discard_nxt;

  logic                           cont_ok;
  logic [u8sd_pkg::CP_W-1:0]      accum_ext;
  logic [u8sd_pkg::CNT_W-1:0]     seen_inc;
  logic [1:0]                     pending_dec;

  always_comb begin
    cont_ok = (data_byte & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_TAG;
    if (seen_r == u8sd_pkg::CNT_W'(1)) begin
      if (lead_r == u8sd_pkg::LEAD_E0 && data_byte <  u8sd_pkg::BOUND_A0) cont_ok = 1'b0;
      if (lead_r == u8sd_pkg::LEAD_ED && data_byte >= u8sd_pkg::BOUND_A0) cont_ok = 1'b0;
      if (lead_r == u8sd_pkg::LEAD_F0 && data_byte <  u8sd_pkg::BOUND_90) cont_ok = 1'b0;
      if (lead_r == u8sd_pkg::LEAD_F4 && data_byte >= u8sd_pkg::BOUND_90) cont_ok = 1'b0;
    end
    accum_ext   = {accum_r[u8sd_pkg::CP_W-7:0], data_byte[5:0]};
    seen_inc    = seen_r + u8sd_pkg::CNT_W'(1);
    pending_dec = pending_r - 2'd1;
  end

  always_comb begin
    pending_nxt = pending_r;
    accum_nxt   = accum_r;
    lead_nxt    = lead_r;
    seen_nxt    = seen_r;
    discard_nxt = discard_r;
    res         = '0;

    if (discard_r) begin
      // drop bytes up to the end of the string
      if (end_of_string) discard_nxt = 1'b0;
    end else if (pending_r == 2'd0) begin
      if (data_byte < u8sd_pkg::ASCII_LIMIT) begin
        res.emit       = 1'b1;
        res.code_point = u8sd_pkg::CP_W'(data_byte);
        res.byte_count = u8sd_pkg::CNT_W'(1);
      end else if (data_byte inside {[u8sd_pkg::LEAD2_MIN:u8sd_pkg::LEAD2_MAX],
                                     [u8sd_pkg::LEAD3_MIN:u8sd_pkg::LEAD3_MAX],
                                     [u8sd_pkg::LEAD4_MIN:u8sd_pkg::LEAD4_MAX]}) begin
        if (data_byte <= u8sd_pkg::LEAD2_MAX) begin
          pending_nxt = 2'd1;
          accum_nxt   = u8sd_pkg::CP_W'(data_byte[4:0]);
        end else if (data_byte <= u8sd_pkg::LEAD3_MAX) begin
          pending_nxt = 2'd2;
          accum_nxt   = u8sd_pkg::CP_W'(data_byte[3:0]);
        end else begin
          pending_nxt = 2'd3;
          accum_nxt   = u8sd_pkg::CP_W'(data_byte[2:0]);
        end
        lead_nxt = data_byte;
        seen_nxt = u8sd_pkg::CNT_W'(1);
        if (end_of_string) begin
          // lead byte cut off by the end of the string
          res.emit       = 1'b1;
          res.byte_count = u8sd_pkg::CNT_W'(1);
          res.invalid    = 1'b1;
          pending_nxt    = 2'd0;
          accum_nxt      = '0;
          lead_nxt       = '0;
          seen_nxt       = '0;
        end
      end else begin
        res.emit       = 1'b1;
        res.byte_count = u8sd_pkg::CNT_W'(1);
        res.invalid    = 1'b1;
        discard_nxt    = !end_of_string;
      end
    end else if (!cont_ok) begin
      res.emit       = 1'b1;
      res.byte_count = seen_inc;
      res.invalid    = 1'b1;
      pending_nxt    = 2'd0;
      accum_nxt      = '0;
      lead_nxt       = '0;
      seen_nxt       = '0;
      discard_nxt    = !end_of_string;
    end else if (pending_dec == 2'd0) begin
      res.emit       = 1'b1;
      res.code_point = accum_ext;
      res.byte_count = seen_inc;
      pending_nxt    = 2'd0;
      accum_nxt      = '0;
      lead_nxt       = '0;
      seen_nxt       = '0;
    end else if (end_of_string) begin
      res.emit       = 1'b1;
      res.byte_count = seen_inc;
      res.invalid    = 1'b1;
      pending_nxt    = 2'd0;
      accum_nxt      = '0;
      lead_nxt       = '0;
      seen_nxt       = '0;
    end else begin
      pending_nxt = pending_dec;
      accum_nxt   = accum_ext;
      seen_nxt    = seen_inc;
    end

    // hold state unless a byte is consumed
    if (!take) begin
      pending_nxt = pending_r;
      accum_nxt   = accum_r;
      lead_nxt    = lead_r;
      seen_nxt    = seen_r;
      discard_nxt = discard_r;
      res.emit    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      accum_r   <= '0;
      lead_r    <= '0;
      seen_r    <= '0;
      discard_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      accum_r   <= accum_nxt;
      lead_r    <= lead_nxt;
      seen_r    <= seen_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/u8sd_out_stage.sv -----
// ----------------------------------------------------------------------------
// u8sd_out_stage
// Result register: holds one decoded character until its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_out_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire u8sd_pkg::result_t             res,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic [u8sd_pkg::CP_W-1:0]          out_code_point,
  output logic [u8sd_pkg::CNT_W-1:0]         out_byte_count,
  output logic                               out_invalid
);

  logic                          vld_r, vld_nxt;
  logic [u8sd_pkg::CP_W-1:0]     cp_r;
  logic [u8sd_pkg::CNT_W-1:0]    cnt_r;
  logic                          bad_r;

  always_comb begin
    vld_nxt = vld_r;
    if (vld_r && !out_stall) vld_nxt = 1'b0;
    if (load)                vld_nxt = res.emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      cp_r  <= res.code_point;
      cnt_r <= res.byte_count;
      bad_r <= res.invalid;
    end
  end

  assign out_valid      = vld_r;
  assign out_code_point = cp_r;
  assign out_byte_count = cnt_r;
  assign out_invalid    = bad_r;

endmodule

`default_nettype wire

// ----- rtl/core/utf8_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Strict UTF-8 decoder: one byte in per transfer, one result per character
// or per malformed sequence.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                  | handshake
//  in_     | input     | data_byte[7:0], end_of_string             | valid/stall
//  out_    | output    | code_point[20:0], byte_count[2:0], invalid| valid/stall
//
//  One byte per clock sustained unless the result register is stalled; a
//  byte passes the input register, then is decoded into the result register,
//  whose valid drives out_valid.
//  Synchronous active-low reset clears the sequence state and both valids.
//  in_stall rises only when a byte is held and the result register is full
//  and stalled; nothing is lost or repeated across stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [u8sd_pkg::BYTE_W-1:0]   in_data_byte,
  input  wire logic                          in_end_of_string,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [u8sd_pkg::CP_W-1:0]          out_code_point,
  output logic [u8sd_pkg::CNT_W-1:0]         out_byte_count,
  output logic                               out_invalid
);

  logic                          in_vld_r, in_vld_nxt;
  logic [u8sd_pkg::BYTE_W-1:0]   in_byte_r;
  logic                          in_eos_r;
  logic                          take;
  logic                          in_xfer;
  u8sd_pkg::result_t             res;

  // advance the held byte once the result register is free or draining
  assign take     = in_vld_r && (!out_valid || !out_stall);
  assign in_stall = in_vld_r && !take;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take)    in_vld_nxt = 1'b0;
    if (in_xfer) in_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_data_byte;
      in_eos_r  <= in_end_of_string;
    end
  end

  u8sd_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .data_byte     (in_byte_r),
    .end_of_string (in_eos_r),
    .res           (res)
  );

  u8sd_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (take),
    .res            (res),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_code_point (out_code_point),
    .out_byte_count (out_byte_count),
    .out_invalid    (out_invalid)
  );

endmodule

`default_nettype wire

// ----- tb/sv/utf8_stream_decoder_unit_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_stream_decoder_unit_checker
// Watches both channels of the UTF-8 stream decoder. Decodes every accepted
// byte with its own strict decoder and compares each result transfer,
// field by field, with the oldest predicted character.
// ---------------------------------------------------------------------------
module utf8_stream_decoder_unit_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [u8sd_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          in_end_of_string,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [u8sd_pkg::CP_W-1:0]     out_code_point,
  input  logic [u8sd_pkg::CNT_W-1:0]    out_byte_count,
  input  logic                          out_invalid,
  output int unsigned                   mismatch_count,
  output int unsigned                   awaiting_count
);

  typedef struct packed {
    logic [u8sd_pkg::CP_W-1:0]  code_point;
    logic [u8sd_pkg::CNT_W-1:0] byte_count;
    logic                       invalid;
  } char_result_t;

  char_result_t expected_chars[$];
  int unsigned  errors;

  // Decoder state
  logic [1:0]                  cont_left;
  logic [u8sd_pkg::CP_W-1:0]   cp_accum;
  logic [u8sd_pkg::BYTE_W-1:0] seq_lead;
  logic [u8sd_pkg::CNT_W-1:0]  seq_len;
  logic                        dropping;

  task automatic emit_char(input logic [u8sd_pkg::CP_W-1:0] cp,
                           input logic [u8sd_pkg::CNT_W-1:0] cnt,
                           input logic bad);
    char_result_t r;
    r.code_point = cp;
    r.byte_count = cnt;
    r.invalid    = bad;
    expected_chars.push_back(r);
  endtask

  task automatic clear_seq();
    cont_left = '0;
    cp_accum  = '0;
    seq_lead  = '0;
    seq_len   = '0;
  endtask

  // Drop the rest of the string unless this byte already ends it
  task automatic flag_error(input logic [u8sd_pkg::CNT_W-1:0] cnt, input logic eos);
    emit_char('0, cnt, 1'b1);
    clear_seq();
    dropping = !eos;
  endtask

  task automatic decode_byte(input logic [u8sd_pkg::BYTE_W-1:0] b, input logic eos);
    logic good;
    if (dropping) begin
      if (eos) dropping = 1'b0;
    end else if (cont_left == 2'd0) begin
      if (b < u8sd_pkg::ASCII_LIMIT) begin
        emit_char(u8sd_pkg::CP_W'(b), u8sd_pkg::CNT_W'(1), 1'b0);
        clear_seq();
      end else if (b >= u8sd_pkg::LEAD2_MIN && b <= u8sd_pkg::LEAD4_MAX) begin
        if (b <= u8sd_pkg::LEAD2_MAX) begin
          cont_left = 2'd1;
          cp_accum  = u8sd_pkg::CP_W'(b[4:0]);
        end else if (b <= u8sd_pkg::LEAD3_MAX) begin
          cont_left = 2'd2;
          cp_accum  = u8sd_pkg::CP_W'(b[3:0]);
        end else begin
          cont_left = 2'd3;
          cp_accum  = u8sd_pkg::CP_W'(b[2:0]);
        end
        seq_lead = b;
        seq_len  = u8sd_pkg::CNT_W'(1);
        if (eos) flag_error(u8sd_pkg::CNT_W'(1), eos);
      end else begin
        flag_error(u8sd_pkg::CNT_W'(1), eos);
      end
    end else begin
      good = (b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_TAG;
      // narrowed second-byte ranges: no overlongs, surrogates or values past the top
      if (good && seq_len == u8sd_pkg::CNT_W'(1)) begin
        if (seq_lead == u8sd_pkg::LEAD_E0 && b <  u8sd_pkg::BOUND_A0) good = 1'b0;
        if (seq_lead == u8sd_pkg::LEAD_ED && b >= u8sd_pkg::BOUND_A0) good = 1'b0;
        if (seq_lead == u8sd_pkg::LEAD_F0 && b <  u8sd_pkg::BOUND_90) good = 1'b0;
        if (seq_lead == u8sd_pkg::LEAD_F4 && b >= u8sd_pkg::BOUND_90) good = 1'b0;
      end
      if (!good) begin
        flag_error(seq_len + u8sd_pkg::CNT_W'(1), eos);
      end else begin
        cp_accum  = {cp_accum[u8sd_pkg::CP_W-7:0], b[5:0]};
        seq_len   = seq_len + u8sd_pkg::CNT_W'(1);
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          emit_char(cp_accum, seq_len, 1'b0);
          clear_seq();
        end else if (eos) begin
          flag_error(seq_len, eos);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    char_result_t want;
    if (!rst_n) begin
      clear_seq();
      dropping = 1'b0;
      expected_chars.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_end_of_string);
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: code_point %h byte_count %0d invalid %b",
                     out_code_point, out_byte_count, out_invalid);
        end else begin
          want = expected_chars.pop_front();
          if (out_code_point !== want.code_point || out_byte_count !== want.byte_count ||
              out_invalid !== want.invalid) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected cp %h cnt %0d inv %b, got cp %h cnt %0d inv %b",
                       want.code_point, want.byte_count, want.invalid,
                       out_code_point, out_byte_count, out_invalid);
          end
        end
      end
    end
    mismatch_count <= errors;
    awaiting_count <= unsigned'(expected_chars.size());
  end

endmodule

// ----- tb/sv/utf8_stream_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_stream_decoder_unit_tb
// Feeds the UTF-8 stream decoder with directed edge cases and then random
// strings, mostly well formed with some damaged, under bursty input and a
// stalling receiver. A checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module utf8_stream_decoder_unit_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned LONG_HOLD    = 100;
  localparam int unsigned RANDOM_BYTES = 600;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                        clk              = 1'b0;
  logic                        rst_n            = 1'b0;
  logic                        in_valid         = 1'b0;
  logic                        in_stall;
  logic [u8sd_pkg::BYTE_W-1:0] in_data_byte     = '0;
  logic                        in_end_of_string = 1'b0;
  logic                        out_valid;
  logic                        out_stall        = 1'b0;
  logic [u8sd_pkg::CP_W-1:0]   out_code_point;
  logic [u8sd_pkg::CNT_W-1:0]  out_byte_count;
  logic                        out_invalid;

  int unsigned mismatch_count;
  int unsigned awaiting_count;

  logic [u8sd_pkg::BYTE_W-1:0] str_bytes[$];
  int unsigned                 bytes_sent;
  int                          burst_left;
  bit                          gaps_on;
  int                          hold_req;

  // bit 8 marks the last byte of a string
  logic [8:0] directed_seq [0:25] = '{
    9'h000, 9'h07F, 9'h0C2, 9'h180,   // zero byte, ASCII top, smallest two-byte
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,   // highest code point
    9'h0E0, 9'h09F, 9'h141,           // overlong three-byte, then dropped tail
    9'h0ED, 9'h0A0, 9'h180,           // surrogate
    9'h0F0, 9'h18F,                   // overlong four-byte at end of string
    9'h0F4, 9'h190,                   // above the top of the range
    9'h180,                           // stray continuation
    9'h1C1,                           // bad lead
    9'h1FF,                           // bad lead
    9'h0E1, 9'h180,                   // cut off after two bytes
    9'h1C3,                           // lead alone at end of string
    9'h0C3, 9'h141                    // broken continuation
  };

  utf8_stream_decoder_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_point   (out_code_point),
    .out_byte_count   (out_byte_count),
    .out_invalid      (out_invalid)
  );

  utf8_stream_decoder_unit_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_point   (out_code_point),
    .out_byte_count   (out_byte_count),
    .out_invalid      (out_invalid),
    .mismatch_count   (mismatch_count),
    .awaiting_count   (awaiting_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one byte and hold it until the transfer; idle between bursts
  task automatic send_byte(input logic [u8sd_pkg::BYTE_W-1:0] b, input logic eos);
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++)
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting_count != 0) @(posedge clk);
  endtask

  // Mostly random inside the range, sometimes one of its ends
  function automatic logic [u8sd_pkg::CP_W-1:0] pick_in(input int unsigned lo,
                                                        input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return u8sd_pkg::CP_W'(lo);
    if (r == 1) return u8sd_pkg::CP_W'(hi);
    return u8sd_pkg::CP_W'($urandom_range(lo, hi));
  endfunction

  task automatic append_char();
    int                        kind;
    logic [u8sd_pkg::CP_W-1:0] cp;
    kind = $urandom_range(0, 19);
    if (kind < 8) begin
      cp = pick_in(0, 'h7F);
      str_bytes.push_back(cp[7:0]);
    end else if (kind < 12) begin
      cp = pick_in('h80, 'h7FF);
      str_bytes.push_back({3'b110, cp[10:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end else if (kind < 17) begin
      cp = pick_in('h800, 'hFFFF);
      // step out of the surrogate block onto one of its neighbours
      if (cp >= 'hD800 && cp <= 'hDFFF)
        cp = $urandom_range(0, 1) ? u8sd_pkg::CP_W'('hD7FF) : u8sd_pkg::CP_W'('hE000);
      str_bytes.push_back({4'b1110, cp[15:12]});
      str_bytes.push_back({2'b10, cp[11:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      cp = pick_in('h10000, 'h10FFFF);
      str_bytes.push_back({5'b11110, cp[20:18]});
      str_bytes.push_back({2'b10, cp[17:12]});
      str_bytes.push_back({2'b10, cp[11:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  task automatic build_string();
    int pos;
    str_bytes.delete();
    repeat ($urandom_range(1, 6)) append_char();
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, str_bytes.size() - 1);
      case ($urandom_range(0, 3))
        0: str_bytes[pos] = u8sd_pkg::BYTE_W'($urandom_range(0, 255));
        1: if (str_bytes.size() > 1) void'(str_bytes.pop_back());
        2: str_bytes[pos] = u8sd_pkg::BYTE_W'($urandom_range(0, 1) ?
                                              $urandom_range('h80, 'hC1) :
                                              $urandom_range('hF5, 'hFF));
        default: begin
          str_bytes.delete();
          repeat ($urandom_range(1, 5))
            str_bytes.push_back(u8sd_pkg::BYTE_W'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // Receiver: random stall modes, plus a long hold-off on request
  initial begin : receiver
    int          hold_served;
    int          hold_left;
    int          mode_left;
    stall_mode_t stall_mode;
    logic        stall_next;
    hold_served = 0;
    hold_left   = 0;
    mode_left   = 0;
    stall_mode  = STALL_NONE;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_served != hold_req) begin
        hold_served++;
        hold_left  = int'(LONG_HOLD) - 1;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE:  stall_next = 1'b0;
          STALL_LIGHT: stall_next = $urandom_range(0, 9) < 3;
          STALL_HEAVY: stall_next = $urandom_range(0, 9) < 7;
          default:     stall_next = (mode_left % 3) == 0;
        endcase
      end
      out_stall <= stall_next;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int holds_started;
    hold_req      = 0;
    holds_started = 0;
    bytes_sent    = 0;
    gaps_on       = 1'b1;
    burst_left    = $urandom_range(1, 24);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);
    drain_results();

    while (bytes_sent < RANDOM_BYTES + 26) begin
      if ((holds_started == 0 && bytes_sent >= 200) ||
          (holds_started == 1 && bytes_sent >= 450)) begin
        // keep offering back to back while the receiver holds off
        holds_started++;
        hold_req <= hold_req + 1;
        gaps_on = 1'b0;
        repeat (12) begin
          build_string();
          send_string();
        end
        gaps_on = 1'b1;
      end else begin
        build_string();
        send_string();
        if ($urandom_range(0, 29) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
